// ===== sv/apf_pkg.sv =====
// Shared types and constants of the all-pole IIR filter.
package apf_pkg;

  // Default and maximum filter order (number of feedback taps).
  localparam int OrderDef  = 6;
  localparam int HistDepth = 6;
  localparam int NumCoef   = 7;

  // Field and register widths.
  localparam int SampleW = 16;
  localparam int CoefW   = 16;
  localparam int CfgIdxW = 3;
  localparam int TapIdxW = 3;

  // Datapath widths: Q22.12 accumulator, rounded dividend magnitude, shifted divisor, quotient.
  localparam int AccW  = 35;
  localparam int RemW  = 34;
  localparam int DvsW  = 32;
  localparam int QuotW = 17;

  // Restoring division: one quotient bit per step, top bit flags overflow.
  localparam int DivSteps = QuotW;
  localparam int DivCntW  = 5;

  // Reset value of the leading coefficient: 1.0 in Q3.12.
  localparam logic signed [CoefW-1:0] CoefLeadRst = 16'sd4096;

  // Saturation limits of the output word.
  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic               load;
    logic               mac;
    logic [TapIdxW-1:0] tap;
    logic               prep;
    logic               div;
    logic               finish;
  } apf_cmd_t;

endpackage

// ===== sv/apf_if.sv =====
// Valid/ready channel interfaces for input and result words.
interface apf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [apf_pkg::SampleW-1:0]   sample_in;
  logic                                 segment_start;

  modport source (output valid, sample_in, segment_start, input ready);
  modport sink   (input valid, sample_in, segment_start, output ready);
endinterface

interface apf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [apf_pkg::SampleW-1:0]   sample_out;
  logic                                 saturated;
  logic                                 lead_zero;

  modport source (output valid, sample_out, saturated, lead_zero, input ready);
  modport sink   (input valid, sample_out, saturated, lead_zero, output ready);
endinterface

// ===== sv/apf_datapath.sv =====
// Datapath: coefficients, output history, multiply-accumulate, serial divider, output word.
module apf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  apf_pkg::apf_cmd_t                   cmd_i,
  input  logic signed [apf_pkg::SampleW-1:0]  sample_i,
  input  logic                                start_i,
  input  logic                                cfg_we_i,
  input  logic [apf_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [apf_pkg::CoefW-1:0]           cfg_data_i,
  output logic signed [apf_pkg::SampleW-1:0]  sample_out_o,
  output logic                                saturated_o,
  output logic                                lead_zero_o
);

  localparam int AccW  = apf_pkg::AccW;
  localparam int RemW  = apf_pkg::RemW;
  localparam int DvsW  = apf_pkg::DvsW;
  localparam int QuotW = apf_pkg::QuotW;
  localparam int SW    = apf_pkg::SampleW;
  localparam int CW    = apf_pkg::CoefW;

  logic signed [CW-1:0]   coef_q [apf_pkg::NumCoef];
  logic signed [SW-1:0]   hist_q [apf_pkg::HistDepth];
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic [DvsW-1:0]        dvs_q, dvs_d;
  logic [QuotW-1:0]       quot_q, quot_d;
  logic                   neg_q, neg_d;
  logic signed [SW-1:0]   y_out_q;
  logic                   sat_q, lz_q;

  logic signed [2*CW-1:0] prod;
  logic [AccW-1:0]        acc_mag;
  logic [CW:0]            den_ext;
  logic [CW-1:0]          den;
  logic [RemW-1:0]        dvs_ext;
  logic [SW-1:0]          quot_lo;
  logic                   lead_zero;
  logic                   sat;
  logic signed [SW-1:0]   y_res;
  logic [apf_pkg::TapIdxW-1:0] hist_idx;

  // Coefficient registers, written through the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= apf_pkg::CoefLeadRst;
      for (int i = 1; i < apf_pkg::NumCoef; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i && (32'(cfg_idx_i) < apf_pkg::NumCoef)) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Output history: cleared at a segment start, shifted when a result is issued.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < apf_pkg::HistDepth; i++) begin
        hist_q[i] <= '0;
      end
    end else if (cmd_i.load && start_i) begin
      for (int i = 0; i < apf_pkg::HistDepth; i++) begin
        hist_q[i] <= '0;
      end
    end else if (cmd_i.finish) begin
      for (int i = apf_pkg::HistDepth - 1; i > 0; i--) begin
        hist_q[i] <= hist_q[i-1];
      end
      hist_q[0] <= y_res;
    end
  end

  // One feedback product per cycle; tap k uses y[n-k].
  assign hist_idx = cmd_i.tap - apf_pkg::TapIdxW'(1);
  assign prod     = coef_q[cmd_i.tap] * hist_q[hist_idx];

  // Sign handling of numerator and divisor, and rounding offset.
  assign lead_zero = (coef_q[0] == '0);
  assign acc_mag   = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
  assign den_ext   = coef_q[0][CW-1] ? (CW+1)'(-{coef_q[0][CW-1], coef_q[0]})
                                     : {1'b0, coef_q[0]};
  assign den       = den_ext[CW-1:0];
  assign dvs_ext   = {{(RemW-DvsW){1'b0}}, dvs_q};

  // Accumulator, divider and sign registers.
  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    neg_d  = neg_q;
    if (cmd_i.load) begin
      acc_d = {{(AccW-SW-12){sample_i[SW-1]}}, sample_i, 12'b0};
    end else if (cmd_i.mac) begin
      acc_d = acc_q - AccW'(prod);
    end else if (cmd_i.prep) begin
      neg_d  = acc_q[AccW-1] ^ coef_q[0][CW-1];
      rem_d  = acc_mag[RemW-1:0] + RemW'(den >> 1);
      dvs_d  = {den, {(DvsW-CW){1'b0}}};
      quot_d = '0;
    end else if (cmd_i.div) begin
      if (rem_q >= dvs_ext) begin
        rem_d  = rem_q - dvs_ext;
        quot_d = {quot_q[QuotW-2:0], 1'b1};
      end else begin
        quot_d = {quot_q[QuotW-2:0], 1'b0};
      end
      dvs_d = dvs_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
    neg_q  <= neg_d;
  end

  // Saturation and sign of the rounded quotient.
  assign quot_lo = quot_q[SW-1:0];
  always_comb begin
    if (neg_q) begin
      sat   = quot_q[QuotW-1] || (quot_lo > 16'd32768);
      y_res = sat ? apf_pkg::SampleMin : SW'(-$signed({1'b0, quot_lo}));
    end else begin
      sat   = quot_q[QuotW-1] || (quot_lo > 16'd32767);
      y_res = sat ? apf_pkg::SampleMax : $signed(quot_lo);
    end
    if (lead_zero) begin
      sat   = 1'b0;
      y_res = '0;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      y_out_q <= y_res;
      sat_q   <= sat;
      lz_q    <= lead_zero;
    end
  end

  assign sample_out_o = y_out_q;
  assign saturated_o  = sat_q;
  assign lead_zero_o  = lz_q;

endmodule

// ===== sv/apf_ctrl.sv =====
// Sequencer: accepts a word, steps the taps and the divider, issues the result word.
module apf_ctrl #(
  parameter int Order = apf_pkg::OrderDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output apf_pkg::apf_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMac  = 5'b00010,
    StPrep = 5'b00100,
    StDiv  = 5'b01000,
    StFin  = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [apf_pkg::TapIdxW-1:0]   tap_q, tap_d;
  logic [apf_pkg::DivCntW-1:0]   div_cnt_q, div_cnt_d;
  logic                          out_valid_q, out_valid_d;
  logic                          accept;
  logic                          finish;

  assign accept = (state_q == StIdle) && in_valid_i;
  assign finish = (state_q == StFin) && (!out_valid_q || out_ready_i);

  // Next state and step counters.
  always_comb begin
    state_d   = state_q;
    tap_d     = tap_q;
    div_cnt_d = div_cnt_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StMac;
          tap_d   = apf_pkg::TapIdxW'(1);
        end
      end
      StMac: begin
        if (tap_q == apf_pkg::TapIdxW'(Order)) begin
          state_d = StPrep;
        end else begin
          tap_d = tap_q + apf_pkg::TapIdxW'(1);
        end
      end
      StPrep: begin
        state_d   = StDiv;
        div_cnt_d = '0;
      end
      StDiv: begin
        if (div_cnt_q == apf_pkg::DivCntW'(apf_pkg::DivSteps - 1)) begin
          state_d = StFin;
        end else begin
          div_cnt_d = div_cnt_q + apf_pkg::DivCntW'(1);
        end
      end
      StFin: begin
        if (finish) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output valid: set when a result is loaded, cleared when it is taken.
  always_comb begin
    priority if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tap_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = accept;
    cmd_o.mac    = (state_q == StMac);
    cmd_o.tap    = tap_q;
    cmd_o.prep   = (state_q == StPrep);
    cmd_o.div    = (state_q == StDiv);
    cmd_o.finish = finish;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/all_pole_iir_filter_top.sv =====
// Top level of the all-pole IIR (LPC synthesis) filter.
//
// Input channel in_ch carries one excitation word (sample_in, segment_start);
// output channel out_ch returns one filtered word (sample_out, saturated,
// lead_zero) for each input word, in order. Both use valid/ready handshakes.
// Coefficients a0..a6 (Q3.12) are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; index 0 is a0, indexes above 6 are ignored. The user must write
// them only while the filter is idle, which the block itself does not enforce.
// Each word runs through Order multiply-accumulate steps (one tap per cycle
// on a single 16x16 multiplier), a sign/rounding step, 17 restoring divide
// steps by a0 and a result step, which waits while the output register holds
// an untaken word; the input is ready again in the cycle after it completes.
// Results sit in an output register; a stalled receiver holds the finished
// word there while the next input word is already accepted and processed, and
// only the hand-over of the following result waits. Reset clears the history,
// sets a0 to 1.0 and a1..a6 to zero, and leaves no result pending.
module all_pole_iir_filter_top #(
  parameter int Order = apf_pkg::OrderDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  apf_in_if.sink                       in_ch,
  apf_out_if.source                    out_ch,
  input  logic                         cfg_we_i,
  input  logic [apf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [apf_pkg::CoefW-1:0]    cfg_data_i
);

  apf_pkg::apf_cmd_t cmd;

  apf_ctrl #(
    .Order (Order)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd)
  );

  apf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sample_i     (in_ch.sample_in),
    .start_i      (in_ch.segment_start),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_out_o (out_ch.sample_out),
    .saturated_o  (out_ch.saturated),
    .lead_zero_o  (out_ch.lead_zero)
  );

  // One word at a time: an accepted word blocks the input until it is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a word is in progress");

  // A zero leading coefficient forces a zero, unclipped result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.lead_zero) |-> (out_ch.sample_out == '0 && !out_ch.saturated))
    else $error("zero a0 result is not zero");

  // A clipped result sits at one of the two range limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.saturated) |->
      (out_ch.sample_out == apf_pkg::SampleMax || out_ch.sample_out == apf_pkg::SampleMin))
    else $error("saturated result is not at a range limit");

endmodule
